// File: rtl/scfr_pkg.sv
// scfr_pkg: shared types and constants of the serial command frame receiver
// no dependencies; used by every design module of the block by scoped names
`default_nettype none

package scfr_pkg;

  localparam logic [7:0] HDR_BYTE       = 8'h55;
  localparam logic [7:0] TAIL_BYTE      = 8'hBB;
  localparam logic [7:0] CODE_A         = 8'h01;
  localparam logic [7:0] CODE_B         = 8'h07;
  localparam logic [7:0] CODE_C         = 8'h08;
  localparam logic [7:0] FRAME_OVERHEAD = 8'd5;
  localparam int         CAP_COUNT      = 6;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CODE,
    PH_LENGTH,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_TAIL = 2'd2
  } status_t;

  // registered input byte handed to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_t;

  // one completed frame, func_code in the lowest bits
  typedef struct packed {
    logic [CAP_COUNT-1:0][7:0] payload;
    status_t                   status;
    logic [5:0]                payload_length;
    logic [7:0]                func_code;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/scfr_in_reg.sv
// scfr_in_reg: input register stage holding one received byte
// depends on scfr_pkg (rx_t)
`default_nettype none

module scfr_in_reg (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [7:0]       in_data,
  input  wire              take,
  output scfr_pkg::rx_t    rx
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       accept;

  assign in_ready  = !valid_r || take;
  assign accept    = in_valid && in_ready;
  assign valid_nxt = accept || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data;
    end
  end

  assign rx.valid = valid_r;
  assign rx.data  = data_r;

endmodule

`default_nettype wire

// File: rtl/scfr_parser.sv
// scfr_parser: frame state machine, running sum and payload capture
// depends on scfr_pkg (phase_t, status_t, rx_t, res_t, byte constants)
`default_nettype none

module scfr_parser #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  wire              clk,
  input  wire              rst_n,
  input  scfr_pkg::rx_t    rx,
  input  wire              csum_en,
  input  wire              out_free,
  output logic             take,
  output logic             emit,
  output scfr_pkg::res_t   res
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES);

  scfr_pkg::phase_t          phase_r, phase_nxt;
  logic [CNT_W-1:0]          len_r, len_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [7:0]                sum_r, sum_nxt;
  logic [7:0]                rsum_r, rsum_nxt;
  logic [7:0]                code_r, code_nxt;
  logic [scfr_pkg::CAP_COUNT-1:0][7:0] cap_r, cap_nxt;
  logic                      hit;
  logic                      too_long;
  logic                      advance;
  logic [7:0]                b;
  scfr_pkg::status_t         status;

  assign b   = rx.data;
  assign hit = (b == scfr_pkg::CODE_A) || (b == scfr_pkg::CODE_B) ||
               (b == scfr_pkg::CODE_C);
  // length plus overhead compared at nine bits so it cannot wrap
  assign too_long = ({1'b0, b} + {1'b0, scfr_pkg::FRAME_OVERHEAD}) >=
                    9'(MAX_FRAME_BYTES);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    rsum_nxt  = rsum_r;
    code_nxt  = code_r;
    cap_nxt   = cap_r;
    emit      = 1'b0;
    if (b != scfr_pkg::TAIL_BYTE) begin
      status = scfr_pkg::ST_BAD_TAIL;
    end else if (csum_en && (sum_r != rsum_r)) begin
      status = scfr_pkg::ST_BAD_SUM;
    end else begin
      status = scfr_pkg::ST_OK;
    end
    case (phase_r)
      scfr_pkg::PH_HEADER: begin
        if (b == scfr_pkg::HDR_BYTE) begin
          phase_nxt = scfr_pkg::PH_CODE;
        end
      end
      scfr_pkg::PH_CODE: begin
        if (hit) begin
          code_nxt  = b;
          phase_nxt = scfr_pkg::PH_LENGTH;
        end else begin
          phase_nxt = scfr_pkg::PH_HEADER;
        end
      end
      scfr_pkg::PH_LENGTH: begin
        if (too_long) begin
          phase_nxt = scfr_pkg::PH_HEADER;
        end else begin
          len_nxt   = b[CNT_W-1:0];
          cnt_nxt   = '0;
          sum_nxt   = '0;
          rsum_nxt  = '0;
          cap_nxt   = '0;
          phase_nxt = scfr_pkg::PH_BODY;
        end
      end
      scfr_pkg::PH_BODY: begin
        if (cnt_r < len_r) begin
          sum_nxt = sum_r + b;
          for (int i = 0; i < scfr_pkg::CAP_COUNT; i++) begin
            if (cnt_r == i[CNT_W-1:0]) begin
              cap_nxt[i] = b;
            end
          end
          cnt_nxt = CNT_W'(cnt_r + 1'b1);
        end else if (cnt_r == len_r) begin
          rsum_nxt = b;
          cnt_nxt  = CNT_W'(cnt_r + 1'b1);
        end else begin
          // tail slot closes the frame whatever the byte
          emit      = 1'b1;
          phase_nxt = scfr_pkg::PH_HEADER;
        end
      end
      default: begin
        phase_nxt = scfr_pkg::PH_HEADER;
      end
    endcase
  end

  // a closing byte waits here while the result register is still full
  assign take    = rx.valid && (!emit || out_free);
  assign advance = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scfr_pkg::PH_HEADER;
    end else if (advance) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      rsum_r <= rsum_nxt;
      code_r <= code_nxt;
      cap_r  <= cap_nxt;
    end
  end

  assign res.payload        = cap_r;
  assign res.status         = status;
  assign res.payload_length = 6'(len_r);
  assign res.func_code      = code_r;

endmodule

`default_nettype wire

// File: rtl/scfr_out_reg.sv
// scfr_out_reg: result register between the parser and the output stream
// depends on scfr_pkg (res_t)
`default_nettype none

module scfr_out_reg (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              load,
  input  scfr_pkg::res_t   res_in,
  output logic             free,
  output logic             out_valid,
  input  wire              out_ready,
  output scfr_pkg::res_t   res_out
);

  logic           valid_r, valid_nxt;
  scfr_pkg::res_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

// File: rtl/serial_command_frame_receiver.sv
// serial_command_frame_receiver: top level, byte stream in, frame requests out
// depends on scfr_pkg, scfr_in_reg, scfr_parser, scfr_out_reg
//
//  channel  | direction | width | contents
//  in_      | slave     | 8     | rx_byte
//  out_     | master    | 64    | func_code, payload_length, frame_status, payload bytes 0..5
//  cfg_     | write     | 1     | checksum_enable
//
// one byte is taken every cycle unless a held result stalls a tail byte; a result leaves
// once its tail byte is accepted, via the input register, the parser and the result register
// reset (synchronous, rst_n low) returns to header hunting with checksum on
// a held result stalls the tail byte of the next frame and the bytes after it; earlier bytes flow
`default_nettype none

module serial_command_frame_receiver #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  // [7:0] func_code, [13:8] payload_length, [15:14] frame_status,
  // [23:16] .. [63:56] payload_byte0 .. payload_byte5
  output logic [63:0] out_tdata,
  input  wire         cfg_wr_en,
  input  wire         cfg_wr_data
);

  logic           csum_en_r;
  logic           take;
  logic           emit;
  logic           free;
  scfr_pkg::rx_t  rx;
  scfr_pkg::res_t res;
  scfr_pkg::res_t res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      csum_en_r <= cfg_wr_data;
    end
  end

  scfr_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .take     (take),
    .rx       (rx)
  );

  scfr_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx       (rx),
    .csum_en  (csum_en_r),
    .out_free (free),
    .take     (take),
    .emit     (emit),
    .res      (res)
  );

  scfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && emit),
    .res_in    (res),
    .free      (free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_q)
  );

  assign out_tdata = res_q;

endmodule

`default_nettype wire

// File: rtl/scfr_checker.sv
// scfr_checker: port-level checks of the frame receiver, bound to the top level
// depends on serial_command_frame_receiver ports only
`default_nettype none

module scfr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [63:0] out_tdata
);

  // a pending request stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before the request was taken");

  // a stalled request keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // status code three is never produced
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:14] != 2'b11)
    else $error("undefined frame status");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("request pending right after reset");

  // a new request needs an input byte offered (accepted or stalled) beforehand, or a reset before it
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!rst_n || (in_tvalid && in_tready), 2) ||
                          $past(in_tvalid && !in_tready, 1) ||
                          $past(in_tvalid && !in_tready, 2) || $past(!rst_n, 1))
    else $error("request without an input byte");

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
